FILE: hw/rtl/tcbc_pkg.sv
// shared constants and types of the ternary coefficient byte codec
package tcbc_pkg;

  localparam int MAX_LENGTH = 2048;
  localparam int POS_W      = $clog2(MAX_LENGTH);
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int CFG_W      = 12;
  localparam int NUM_DIGITS = 5;
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam logic [7:0] BYTE_MOD       = 8'd243;
  localparam logic [CFG_W-1:0] LEN_RESET = 12'd761;

  typedef enum logic {
    REG_MODE   = 1'b0,
    REG_LENGTH = 1'b1
  } tcbc_reg_e;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } tcbc_mode_e;

  localparam logic [1:0] TRIT_ZERO = 2'b00;
  localparam logic [1:0] TRIT_POS  = 2'b01;
  localparam logic [1:0] TRIT_NEG  = 2'b11;

  typedef struct packed {
    tcbc_mode_e                       mode;
    logic [7:0]                       byte_val;
    logic [NUM_DIGITS-1:0][1:0]       trits;
    logic [DIG_W-1:0]                 count;
    logic                             at_end;
  } tcbc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tcbc_qstat_t;

  function automatic logic [7:0] pow3(input logic [2:0] e);
    logic [7:0] r;
    case (e)
      3'd0:    r = 8'd1;
      3'd1:    r = 8'd3;
      3'd2:    r = 8'd9;
      3'd3:    r = 8'd27;
      3'd4:    r = 8'd81;
      default: r = 8'd243;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/tcbc_if.sv
// valid/ready channel interfaces for input and result words
interface tcbc_in_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] trit_in;
  logic        [7:0] byte_in;
  modport source (output valid, trit_in, byte_in, input ready);
  modport sink   (input valid, trit_in, byte_in, output ready);
endinterface

interface tcbc_out_if;
  logic              valid;
  logic              ready;
  logic        [7:0] byte_out;
  logic signed [1:0] trit_out;
  logic              last_of_run;
  logic              end_of_poly;
  modport source (output valid, byte_out, trit_out, last_of_run, end_of_poly, input ready);
  modport sink   (input valid, byte_out, trit_out, last_of_run, end_of_poly, output ready);
endinterface

FILE: hw/rtl/tcbc_front.sv
// front end: config registers, input accept, digit packing and byte splitting
module tcbc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [tcbc_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                 [1:0]   trit_in_i,
  input  logic                 [7:0]   byte_in_i,
  input  tcbc_pkg::tcbc_qstat_t        qstat_i,
  output logic                         push_o,
  output tcbc_pkg::tcbc_entry_t        entry_o
);
  import tcbc_pkg::*;

  tcbc_mode_e        mode_q;
  logic [CFG_W-1:0]  poly_length_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        acc_q, acc_d;
  logic [DIG_W-1:0]  cnt_q, cnt_d;

  logic              accept;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  pos_ext;
  logic [LEN_W:0]    pos_inc;
  logic [LEN_W-1:0]  rem;
  logic [DIG_W-1:0]  n_dec;
  logic [LEN_W:0]    pos_adv;
  logic              end_enc, end_dec;
  logic [1:0]        digit;
  logic [7:0]        acc_new;
  logic [DIG_W-1:0]  cnt_new;
  logic [15:0]       padded;
  logic [7:0]        b_red;
  logic [7:0]        r;
  logic [7:0]        p;
  logic [NUM_DIGITS-1:0][1:0] trits;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (poly_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(poly_length_q) > MAX_LENGTH) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = LEN_W'(poly_length_q);
    end
  end

  assign pos_ext = LEN_W'(pos_q);
  assign pos_inc = {1'b0, pos_ext} + (LEN_W+1)'(1);
  assign end_enc = pos_inc >= {1'b0, len_eff};

  // encode path
  assign digit   = trit_in_i[1] ? 2'd2 : {1'b0, trit_in_i[0]};
  assign acc_new = 8'((acc_q << 1) + acc_q) + {6'b0, digit};
  assign cnt_new = cnt_q + DIG_W'(1);
  assign padded  = acc_new * pow3(3'(DIG_W'(NUM_DIGITS) - cnt_new));

  // decode path
  assign rem = len_eff - pos_ext;
  always_comb begin
    if (pos_ext < len_eff) begin
      n_dec = (rem < LEN_W'(NUM_DIGITS)) ? DIG_W'(rem) : DIG_W'(NUM_DIGITS);
    end else begin
      n_dec = DIG_W'(1);
    end
  end
  assign pos_adv = {1'b0, pos_ext} + (LEN_W+1)'(n_dec);
  assign end_dec = (pos_ext >= len_eff) || (pos_adv >= {1'b0, len_eff});

  always_comb begin
    b_red = (byte_in_i >= BYTE_MOD) ? byte_in_i - BYTE_MOD : byte_in_i;
    r     = b_red;
    p     = '0;
    trits = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      p = pow3(3'(NUM_DIGITS - 1 - j));
      if (r >= 8'(p << 1)) begin
        trits[j] = TRIT_NEG;
        r        = r - 8'(p << 1);
      end else if (r >= p) begin
        trits[j] = TRIT_POS;
        r        = r - p;
      end else begin
        trits[j] = TRIT_ZERO;
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.mode = mode_q;
    if (mode_q == MODE_ENCODE) begin
      entry_o.byte_val = padded[7:0];
      entry_o.count    = DIG_W'(1);
      entry_o.at_end   = end_enc;
      if (accept) begin
        if (cnt_new >= DIG_W'(NUM_DIGITS) || end_enc) begin
          push_o = 1'b1;
          acc_d  = '0;
          cnt_d  = '0;
          pos_d  = end_enc ? '0 : POS_W'(pos_inc);
        end else begin
          acc_d  = acc_new;
          cnt_d  = cnt_new;
          pos_d  = POS_W'(pos_inc);
        end
      end
    end else begin
      entry_o.trits  = trits;
      entry_o.count  = n_dec;
      entry_o.at_end = end_dec;
      if (accept) begin
        push_o = 1'b1;
        pos_d  = end_dec ? '0 : POS_W'(pos_adv);
      end
    end
    if (cfg_we_i) begin
      pos_d = '0;
      acc_d = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ENCODE;
      poly_length_q <= LEN_RESET;
      pos_q         <= '0;
      acc_q         <= '0;
      cnt_q         <= '0;
    end else begin
      pos_q <= pos_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (tcbc_reg_e'(cfg_index_i))
          REG_MODE:   mode_q        <= tcbc_mode_e'(cfg_data_i[0]);
          REG_LENGTH: poly_length_q <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

endmodule

FILE: hw/rtl/tcbc_queue.sv
// short word queue between front end and back end
module tcbc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcbc_pkg::tcbc_entry_t entry_i,
  input  logic                  pop_i,
  output tcbc_pkg::tcbc_entry_t head_o,
  output tcbc_pkg::tcbc_qstat_t qstat_o
);
  import tcbc_pkg::*;

  tcbc_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign qstat_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign qstat_o.empty = cnt_q == '0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == QDEPTH - 1) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == QDEPTH - 1) ? '0 : rd_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/tcbc_back.sv
// back end: walks the queue head and emits one result word per cycle while a word is queued and the output is ready
module tcbc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcbc_pkg::tcbc_entry_t head_i,
  input  tcbc_pkg::tcbc_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic            [7:0] byte_out_o,
  output logic            [1:0] trit_out_o,
  output logic                  last_of_run_o,
  output logic                  end_of_poly_o
);
  import tcbc_pkg::*;

  logic [IDX_W-1:0] k_q, k_d;
  logic             last;

  assign out_valid_o   = !qstat_i.empty;
  assign last          = DIG_W'(k_q) + DIG_W'(1) >= head_i.count;
  assign byte_out_o    = (head_i.mode == MODE_ENCODE) ? head_i.byte_val : 8'd0;
  assign trit_out_o    = (head_i.mode == MODE_ENCODE) ? TRIT_ZERO : head_i.trits[k_q];
  assign last_of_run_o = last;
  assign end_of_poly_o = last && head_i.at_end;

  always_comb begin
    k_d   = k_q;
    pop_o = 1'b0;
    if (out_valid_o && out_ready_i) begin
      if (last) begin
        pop_o = 1'b1;
        k_d   = '0;
      end else begin
        k_d   = k_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

endmodule

FILE: hw/rtl/ternary_coefficient_byte_codec.sv
// top level of the ternary coefficient byte codec
//
//  channel  dir  handshake          payload
//  in_i     in   valid/ready        trit_in[1:0] signed, byte_in[7:0]
//  out_o    out  valid/ready        byte_out[7:0], trit_out[1:0] signed,
//                                   last_of_run, end_of_poly
//  cfg      in   cfg_we_i, no ready cfg_index_i, cfg_data_i[11:0]
//
// encode: one trit word per cycle while the queue has room, a byte every fifth trit or at the polynomial end
// decode: each byte word gives five trits (fewer at the end), which the back
//   end emits one trit per cycle from the queue head while the output is ready
// reset is asynchronous and clears all state but the queue storage at once, no clearing pass
// a two-entry queue lets input keep flowing while a result word stalls
module ternary_coefficient_byte_codec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [tcbc_pkg::CFG_W-1:0] cfg_data_i,
  tcbc_in_if.sink                    in_i,
  tcbc_out_if.source                 out_o
);
  import tcbc_pkg::*;

  tcbc_entry_t push_entry, head;
  tcbc_qstat_t qstat;
  logic        push, pop;

  tcbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .trit_in_i   (in_i.trit_in),
    .byte_in_i   (in_i.byte_in),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tcbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  tcbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .byte_out_o    (out_o.byte_out),
    .trit_out_o    (out_o.trit_out),
    .last_of_run_o (out_o.last_of_run),
    .end_of_poly_o (out_o.end_of_poly)
  );

endmodule

FILE: hw/rtl/tcbc_checker.sv
// port-level checker of the codec and its bind
module tcbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] byte_out_i,
  input logic [1:0] trit_out_i,
  input logic       last_of_run_i,
  input logic       end_of_poly_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i)
      && $stable(trit_out_i))
    else $error("result word dropped or changed while stalled");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_of_poly_i |-> last_of_run_i)
    else $error("polynomial end not on last word of run");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_out_i <= 8'd242)
    else $error("packed byte out of range");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_out_i != 8'd0 |-> trit_out_i == 2'b00)
    else $error("byte and trit both set in one word");

  a_trit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> trit_out_i != 2'b10)
    else $error("illegal trit code");

endmodule

bind ternary_coefficient_byte_codec tcbc_checker u_tcbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .byte_out_i    (out_o.byte_out),
  .trit_out_i    (out_o.trit_out),
  .last_of_run_i (out_o.last_of_run),
  .end_of_poly_i (out_o.end_of_poly)
);
